FILE: rtl/psc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psc_pkg: shared constants for the procedural sky color pipeline
// All internal constants are real values scaled by 65536 (Q.16), rounded.
// ----------------------------------------------------------------------------
package psc_pkg;

	// fixed point basics
	localparam int ONE16 = 65536;
	localparam int HALF  = 32768;
	localparam int NCH   = 3;

	// sun direction normalize(1, 0.2, 0), x and y parts
	localparam int SUN_X_Q16 = 64263;
	localparam int SUN_Y_Q16 = 12853;

	// height scale 0.8, horizon base 0.9, white sun disk 0.95
	localparam int SCALE_K  = 52429;
	localparam int HZ_BASE  = 58982;
	localparam int WHITE_K  = 62259;

	// per channel colors: red, green, blue order
	localparam int BLUE_Q16  [NCH] = '{19661, 36045, 52429};
	localparam int RED_Q16   [NCH] = '{52429, 52429, 39322};
	localparam int TINT_Q16  [NCH] = '{13107, 9175, 9175};
	localparam int HORIZ_Q16 [NCH] = '{53084, 44237, 47186};

endpackage
`default_nettype wire

FILE: rtl/procedural_sky_color.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one beat per cycle; the whole 15 stage pipe advances together
// and holds only while the output register carries a beat not yet taken.
// Reset clears the stage valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
// procedural_sky_color: sky gradient with sun for one view direction
// Downward rays give black; others get a sun lit gradient blended toward
// the horizon color, clamped to 0..1.0 and sent out in Q1.FRAC_BITS.
// ----------------------------------------------------------------------------
module procedural_sky_color import psc_pkg::*; #(
	parameter int FRAC_BITS = 15
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // dir_x, dir_y, dir_z
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata    // red, green, blue
);

	localparam int QW  = (FRAC_BITS < 16) ? 32 - FRAC_BITS : 16;
	localparam int MW  = (QW > 17) ? QW : 17;
	localparam int SW  = MW + 2;
	localparam int BW  = MW + 1;
	localparam int W1  = 2 * BW - 16;
	localparam int W2  = 2 * W1 - 16;
	localparam int W3  = 2 * W2 - 16;
	localparam int C4W = SW + W3 - 8;
	localparam int UW  = 22;
	localparam int LIM = (FRAC_BITS >= 16) ? 65535 : (1 << FRAC_BITS);
	localparam int NST = 15;

	// pipe advance: the output register is empty or being taken
	logic en;
	logic valid_s [1:NST];
	assign en       = !valid_s[NST] || m_tready;
	assign s_tready = en;
	assign m_tvalid = valid_s[NST];

	// direction unpack, dir_z has no effect on the color
	logic signed [15:0]   dir_x;
	logic signed [15:0]   dir_y;
	logic signed [QW-1:0] dx_q;
	logic signed [QW-1:0] dy_q;
	assign dir_x = s_tdata[15:0];
	assign dir_y = s_tdata[31:16];

	// input to Q.16
	if (FRAC_BITS <= 16) begin : g_up
		assign dx_q = QW'(dir_x) <<< (16 - FRAC_BITS);
		assign dy_q = QW'(dir_y) <<< (16 - FRAC_BITS);
	end else begin : g_dn
		assign dx_q = QW'(dir_x >>> (FRAC_BITS - 16));
		assign dy_q = QW'(dir_y >>> (FRAC_BITS - 16));
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NST; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else if (en) begin
			valid_s[1] <= s_tvalid;
			for (int k = 1; k < NST; k++) begin
				valid_s[k+1] <= valid_s[k];
			end
		end
	end

	// downward ray flag travels with the beat
	logic neg_s [1:NST-1];
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s[1] <= dir_y[15];
			for (int k = 1; k < NST - 1; k++) begin
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	// sun terms
	logic        [16:0]   t_s6;
	logic        [16:0]   s_s6;
	logic signed [SW-1:0] scale_s7;
	logic        [15:0]   wh_s11;
	logic        [W3-1:0] w3_s12;

	psc_sun #(
		.QW(QW), .SW(SW), .BW(BW), .W1(W1), .W2(W2), .W3(W3)
	) u_sun (
		.clk      (clk),
		.en       (en),
		.dx       (dx_q),
		.dy       (dy_q),
		.t_s6     (t_s6),
		.s_s6     (s_s6),
		.scale_s7 (scale_s7),
		.wh_s11   (wh_s11),
		.w3_s12   (w3_s12)
	);

	// color lanes and output conversion
	logic [15:0] rgb_s15 [NCH];

	for (genvar i = 0; i < NCH; i++) begin : g_ch
		logic signed [C4W-1:0] c_s14;
		logic        [16:0]    cl;
		logic        [UW-1:0]  u;

		psc_channel #(
			.CH(i), .SW(SW), .W3(W3), .C4W(C4W)
		) u_ch (
			.clk      (clk),
			.en       (en),
			.t_s6     (t_s6),
			.s_s6     (s_s6),
			.scale_s7 (scale_s7),
			.wh_s11   (wh_s11),
			.w3_s12   (w3_s12),
			.c_s14    (c_s14)
		);

		// clamp to 0..1.0
		always_comb begin
			if (c_s14 < C4W'(0)) begin
				cl = '0;
			end else if (c_s14 > C4W'(ONE16)) begin
				cl = 17'(ONE16);
			end else begin
				cl = c_s14[16:0];
			end
		end

		// round to the output format
		if (FRAC_BITS < 16) begin : g_rnd
			assign u = (UW'(cl) + UW'(1 << (15 - FRAC_BITS))) >> (16 - FRAC_BITS);
		end else begin : g_shl
			assign u = UW'(cl) << (FRAC_BITS - 16);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (neg_s[NST-1]) begin
					rgb_s15[i] <= '0;
				end else if (u > UW'(LIM)) begin
					rgb_s15[i] <= 16'(LIM);
				end else begin
					rgb_s15[i] <= u[15:0];
				end
			end
		end
	end

	assign m_tdata = {rgb_s15[2], rgb_s15[1], rgb_s15[0]};

endmodule
`default_nettype wire

FILE: rtl/psc_sun.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psc_sun: sun term pipeline
// Dot product with the sun, the power chain s^2 .. s^256, the height scale
// and the horizon weight (0.9 - dy)^8, each aligned to the stage that uses it.
// ----------------------------------------------------------------------------
module psc_sun import psc_pkg::*; #(
	parameter int QW = 17,
	parameter int SW = 19,
	parameter int BW = 18,
	parameter int W1 = 20,
	parameter int W2 = 24,
	parameter int W3 = 32
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic signed [QW-1:0] dx,
	input  wire logic signed [QW-1:0] dy,
	output logic             [16:0]   t_s6,
	output logic             [16:0]   s_s6,
	output logic signed      [SW-1:0] scale_s7,
	output logic             [15:0]   wh_s11,
	output logic             [W3-1:0] w3_s12
);

	localparam int PW  = QW + 18;
	localparam int BPW = 2 * BW;
	localparam int W1P = 2 * W1;
	localparam int W2P = 2 * W2;

	// q.16 square with round half up, for values in 0..1.0
	function automatic logic [16:0] sq_q16(input logic [16:0] a);
		logic [33:0] p;
		p = 34'(a) * 34'(a) + 34'(HALF);
		return p[32:16];
	endfunction

	// stage 1: dot product, height scale, horizon base
	logic signed [PW-1:0] pxy_d;
	logic signed [PW-1:0] scm_p;
	logic signed [SW-1:0] scale_d;
	logic signed [BW-1:0] b_d;
	assign pxy_d   = PW'(dx) * PW'(SUN_X_Q16) + PW'(dy) * PW'(SUN_Y_Q16);
	assign scm_p   = PW'(dy) * PW'(SCALE_K) + PW'(HALF);
	assign scale_d = SW'(ONE16) - SW'(scm_p >>> 16);
	assign b_d     = BW'(HZ_BASE) - BW'(dy);

	logic signed [PW-1:0] pxy_s1;
	logic signed [BW-1:0] b_s1;
	logic signed [SW-1:0] scale_s [1:7];

	always_ff @(posedge clk) begin
		if (en) begin
			pxy_s1     <= pxy_d;
			b_s1       <= b_d;
			scale_s[1] <= scale_d;
			for (int k = 1; k < 7; k++) begin
				scale_s[k+1] <= scale_s[k];
			end
		end
	end
	assign scale_s7 = scale_s[7];

	// stage 2: clamp the dot product into s
	logic signed [PW-1:0] pr;
	logic        [16:0]   s_d;
	assign pr = (pxy_s1 + PW'(HALF)) >>> 16;
	always_comb begin
		if (pxy_s1 < PW'(1)) begin
			s_d = '0;
		end else if (pr > PW'(ONE16)) begin
			s_d = 17'(ONE16);
		end else begin
			s_d = pr[16:0];
		end
	end

	// power chain: sp_s[k] holds s^(2^(k-2)), s^8 at stage 5, s^256 at stage 10
	logic [16:0] sp_s [2:10];
	logic [16:0] sd_s [2:6];

	always_ff @(posedge clk) begin
		if (en) begin
			sp_s[2] <= s_d;
			sd_s[2] <= s_d;
			for (int k = 2; k < 10; k++) begin
				sp_s[k+1] <= sq_q16(sp_s[k]);
			end
			for (int k = 2; k < 6; k++) begin
				sd_s[k+1] <= sd_s[k];
			end
		end
	end
	assign s_s6 = sd_s[6];

	// stage 6: lerp factor 1.5 * s^8
	logic [18:0] t3;
	assign t3 = 19'(sp_s[5]) * 19'd3 + 19'd1;
	always_ff @(posedge clk) begin
		if (en) begin
			t_s6 <= t3[17:1];
		end
	end

	// stage 11: white sun disk term 0.95 * s^256
	logic [33:0] whp;
	assign whp = 34'(sp_s[10]) * 34'(WHITE_K) + 34'(HALF);
	always_ff @(posedge clk) begin
		if (en) begin
			wh_s11 <= whp[31:16];
		end
	end

	// horizon weight: three squarings of (0.9 - dy), stages 2 to 4
	logic signed [BPW-1:0] bsq_p;
	logic        [W1P-1:0] w1_p;
	logic        [W2P-1:0] w2_p;
	logic        [W1-1:0]  w1_s2;
	logic        [W2-1:0]  w2_s3;
	logic        [W3-1:0]  w3_s [4:12];
	logic signed [BPW-1:0] bsq_r;
	assign bsq_p = BPW'(b_s1) * BPW'(b_s1);
	assign bsq_r = (bsq_p + BPW'(HALF)) >>> 16;
	assign w1_p  = W1P'(w1_s2) * W1P'(w1_s2) + W1P'(HALF);
	assign w2_p  = W2P'(w2_s3) * W2P'(w2_s3) + W2P'(HALF);

	always_ff @(posedge clk) begin
		if (en) begin
			w1_s2   <= bsq_r[W1-1:0];
			w2_s3   <= w1_p[W1P-1:16];
			w3_s[4] <= w2_p[W2P-1:16];
			for (int k = 4; k < 12; k++) begin
				w3_s[k+1] <= w3_s[k];
			end
		end
	end
	assign w3_s12 = w3_s[12];

endmodule
`default_nettype wire

FILE: rtl/psc_channel.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psc_channel: color lane for one channel
// Blue to red lerp, height scale, tint and sun disk terms, then the blend
// toward the horizon color; result in signed Q.16 at stage 14.
// ----------------------------------------------------------------------------
module psc_channel import psc_pkg::*; #(
	parameter int CH  = 0,
	parameter int SW  = 19,
	parameter int W3  = 32,
	parameter int C4W = 43
) (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire logic        [16:0]    t_s6,
	input  wire logic        [16:0]    s_s6,
	input  wire logic signed [SW-1:0]  scale_s7,
	input  wire logic        [15:0]    wh_s11,
	input  wire logic        [W3-1:0]  w3_s12,
	output logic signed      [C4W-1:0] c_s14
);

	localparam int C0W = 19;
	localparam int T0W = 38;
	localparam int P1W = C0W + SW;
	localparam int C1W = C0W + SW - 15;
	localparam int C2W = C1W + 1;
	localparam int C3W = C2W + 1;
	localparam int DW  = C3W + 1;
	localparam int P4W = DW + W3 + 1;
	localparam int RB  = RED_Q16[CH] - BLUE_Q16[CH];

	// stage 7: lerp from blue toward red, tint term
	logic signed [T0W-1:0] p0;
	logic        [33:0]    tp;
	logic signed [C0W-1:0] c0_s7;
	logic        [15:0]    tnt_s7;
	assign p0 = T0W'(RB) * T0W'($signed({1'b0, t_s6}));
	assign tp = 34'(s_s6) * 34'(TINT_Q16[CH]) + 34'(HALF);

	always_ff @(posedge clk) begin
		if (en) begin
			c0_s7  <= C0W'(T0W'(BLUE_Q16[CH]) + ((p0 + T0W'(HALF)) >>> 16));
			tnt_s7 <= tp[31:16];
		end
	end

	// stage 8: height scale
	logic signed [P1W-1:0] p1;
	logic signed [C1W-1:0] c1_s8;
	logic        [15:0]    tnt_s8;
	assign p1 = P1W'(c0_s7) * P1W'(scale_s7);

	always_ff @(posedge clk) begin
		if (en) begin
			c1_s8  <= C1W'((p1 + P1W'(HALF)) >>> 16);
			tnt_s8 <= tnt_s7;
		end
	end

	// stages 9 to 11: add tint, wait for the sun disk term
	logic signed [C2W-1:0] c2_s [9:11];
	always_ff @(posedge clk) begin
		if (en) begin
			c2_s[9]  <= C2W'(c1_s8) + C2W'($signed({1'b0, tnt_s8}));
			c2_s[10] <= c2_s[9];
			c2_s[11] <= c2_s[10];
		end
	end

	// stage 12: add sun disk
	logic signed [C3W-1:0] c3_s12;
	always_ff @(posedge clk) begin
		if (en) begin
			c3_s12 <= C3W'(c2_s[11]) + C3W'($signed({1'b0, wh_s11}));
		end
	end

	// stage 13: horizon blend product
	logic signed [DW-1:0]  d;
	logic signed [P4W-1:0] prod_s13;
	logic signed [C3W-1:0] c3_s13;
	assign d = DW'(HORIZ_Q16[CH]) - DW'(c3_s12);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s13 <= P4W'(d) * P4W'($signed({1'b0, w3_s12}));
			c3_s13   <= c3_s12;
		end
	end

	// stage 14: finish the blend
	always_ff @(posedge clk) begin
		if (en) begin
			c_s14 <= C4W'(c3_s13) + C4W'((prod_s13 + P4W'(HALF)) >>> 16);
		end
	end

endmodule
`default_nettype wire

FILE: tb/sv/procedural_sky_color_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// procedural_sky_color_tb: self-checking bench for the sky color pipeline
// Streams view directions into the block, predicts each color in fixed point
// and compares every output beat, field by field, against the oldest
// prediction. Both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module procedural_sky_color_tb;

	localparam int FRAC_BITS = 15;
	localparam int QSH       = 16 - FRAC_BITS;
	localparam int N_RANDOM  = 2000;
	localparam int DRAIN_CYC = 40;

	// Q.16 constants of the sky model
	localparam longint SUN_X    = 64263;
	localparam longint SUN_Y    = 12853;
	localparam longint HEIGHT_K = 52429;
	localparam longint HZ_K     = 58982;
	localparam longint DISK_K   = 62259;
	localparam longint ONE_Q16  = 65536;
	localparam longint ZENITH_C  [3] = '{19661, 36045, 52429};
	localparam longint GLOW_C    [3] = '{52429, 52429, 39322};
	localparam longint TINT_C    [3] = '{13107, 9175, 9175};
	localparam longint HORIZON_C [3] = '{53084, 44237, 47186};

	// one input beat, dir_x in the low bits
	typedef struct packed {
		logic signed [15:0] z;
		logic signed [15:0] y;
		logic signed [15:0] x;
	} view_dir_t;

	// one output beat, red in the low bits
	typedef struct packed {
		logic [15:0] blue;
		logic [15:0] green;
		logic [15:0] red;
	} sky_rgb_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;

	// no idling on either side while set
	bit quiet;

	// rounded Q.16 product
	function automatic longint q16_mul(longint a, longint b);
		return (a * b + 32768) >>> 16;
	endfunction

	// expected color for one direction
	function automatic sky_rgb_t predict_sky(view_dir_t d);
		longint dx, dy, p, s, s8, s256, t, scale, b, w, c, u;
		longint chan [3];
		sky_rgb_t rgb;
		if (d.y < 0) begin
			return '0;
		end
		dx = longint'(d.x) <<< QSH;
		dy = longint'(d.y) <<< QSH;

		// clamped sun alignment
		p = dx * SUN_X + dy * SUN_Y;
		s = (p <= 0) ? 0 : ((p + 32768) >>> 16);
		if (s > ONE_Q16)
			s = ONE_Q16;

		// s^8 and s^256 by repeated squaring
		s8 = q16_mul(s, s);
		s8 = q16_mul(s8, s8);
		s8 = q16_mul(s8, s8);
		s256 = s;
		for (int i = 0; i < 8; i++)
			s256 = q16_mul(s256, s256);

		t = (3 * s8 + 1) >>> 1;
		scale = ONE_Q16 - q16_mul(HEIGHT_K, dy);

		// horizon weight (0.9 - dy)^8
		b = HZ_K - dy;
		w = q16_mul(b, b);
		w = q16_mul(w, w);
		w = q16_mul(w, w);

		for (int i = 0; i < 3; i++) begin
			c = ZENITH_C[i] + q16_mul(GLOW_C[i] - ZENITH_C[i], t);
			c = q16_mul(c, scale);
			c += q16_mul(TINT_C[i], s);
			c += q16_mul(DISK_K, s256);
			c += q16_mul(HORIZON_C[i] - c, w);
			if (c < 0)
				c = 0;
			if (c > ONE_Q16)
				c = ONE_Q16;
			u = (c + (longint'(1) << (QSH - 1))) >> QSH;
			if (u > (longint'(1) << FRAC_BITS))
				u = longint'(1) << FRAC_BITS;
			chan[i] = u;
		end
		rgb.red   = chan[0][15:0];
		rgb.green = chan[1][15:0];
		rgb.blue  = chan[2][15:0];
		return rgb;
	endfunction

	// pending colors in input order
	class sky_scoreboard;
		sky_rgb_t    pending_rgb[$];
		int unsigned errors;

		function new();
			errors = 0;
		endfunction

		function void note_dir(view_dir_t d);
			pending_rgb.push_back(predict_sky(d));
		endfunction

		function void check_rgb(sky_rgb_t got);
			sky_rgb_t want;
			if (pending_rgb.size() == 0) begin
				$error("output beat with no color pending: %h", got);
				errors++;
				return;
			end
			want = pending_rgb.pop_front();
			if (got.red !== want.red) begin
				$error("red: expected %0d, got %0d", want.red, got.red);
				errors++;
			end
			if (got.green !== want.green) begin
				$error("green: expected %0d, got %0d", want.green, got.green);
				errors++;
			end
			if (got.blue !== want.blue) begin
				$error("blue: expected %0d, got %0d", want.blue, got.blue);
				errors++;
			end
		endfunction

		function int unsigned outstanding();
			return pending_rgb.size();
		endfunction
	endclass

	sky_scoreboard sky_sb = new();

	procedural_sky_color #(
		.FRAC_BITS(FRAC_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// output monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sky_sb.check_rgb(m_tdata);
	end

	// send one direction and wait for its accepting edge
	task automatic send_dir(input logic signed [15:0] x, y, z);
		view_dir_t d;
		d.x = x;
		d.y = y;
		d.z = z;
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sky_sb.note_dir(d);
	endtask

	// random source gap between beats
	task automatic source_gap();
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// random direction: mostly upward, some near the sun, some raw noise
	task automatic send_random_dir();
		int unsigned pick;
		logic signed [15:0] x, y, z;
		pick = $urandom_range(0, 99);
		z = 16'($urandom);
		if (pick < 55) begin
			x = 16'($urandom);
			y = 16'($urandom_range(0, 32767));
		end else if (pick < 85) begin
			x = 16'($urandom_range(30000, 32767));
			y = 16'($urandom_range(3000, 10000));
		end else begin
			x = 16'($urandom);
			y = 16'($urandom);
		end
		send_dir(x, y, z);
	endtask

	// output stall bursts
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	// stimulus and end of run
	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		quiet    = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// downward rays
		send_dir(16'sd0, -16'sd1, 16'sd0);
		send_dir(-16'sd32768, -16'sd32768, -16'sd32768);
		send_dir(16'sd32767, -16'sd32768, 16'sd32767);
		// horizon and away from the sun
		send_dir(16'sd0, 16'sd0, 16'sd0);
		send_dir(16'sd32767, 16'sd0, 16'sd0);
		send_dir(-16'sd32768, 16'sd0, 16'sd32767);
		send_dir(-16'sd1, 16'sd0, -16'sd1);
		send_dir(16'sd0, 16'sd1, 16'sd0);
		send_dir(16'sd1, 16'sd1, 16'sd1);
		// straight at the sun, sun disk at full strength
		send_dir(16'sd32130, 16'sd6426, 16'sd0);
		source_gap();
		// non-unit input with alignment capped at one
		send_dir(16'sd32767, 16'sd32767, -16'sd32768);
		send_dir(16'sd32767, 16'sd32767, 16'sd32767);
		// high rays, horizon base at zero or goes negative for most
		send_dir(16'sd0, 16'sd32767, 16'sd0);
		send_dir(16'sd0, 16'sd29491, 16'sd0);
		send_dir(16'sd14000, 16'sd29000, 16'sd0);
		send_dir(-16'sd32768, 16'sd32767, 16'sd0);
		source_gap();
		// blend past the glow color
		send_dir(16'sd30000, 16'sd12000, 16'sd5000);
		send_dir(16'sd32000, 16'sd3000, -16'sd7000);
		send_dir(16'sd23170, 16'sd0, 16'sd23170);
		send_dir(16'sd16384, 16'sd28378, 16'sd0);
		send_dir(-16'sd20000, 16'sd20000, 16'sd20000);

		// random part, with a calm window in the middle and at the end
		for (int n = 0; n < N_RANDOM; n++) begin
			quiet = (n >= 900 && n < 1100) || (n >= N_RANDOM - 200);
			source_gap();
			send_random_dir();
		end
		s_tvalid <= 1'b0;

		while (sky_sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (sky_sb.errors == 0 && sky_sb.outstanding() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
